// File: design/pfi_pkg.sv
// Shared types and constants for the PCM float/int16 sample converter.
package pfi_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned CfgAddrW = 8;

    localparam logic [CfgAddrW-1:0] CfgSourceFormat = 8'd0;
    localparam logic [CfgAddrW-1:0] CfgTargetFormat = 8'd1;

    localparam logic FmtInt16 = 1'b0;
    localparam logic FmtFloat = 1'b1;

    localparam logic [30:0] FloatOneMag = 31'h3F80_0000;

    typedef struct packed {
        logic [WordW-1:0] sample_word;
        logic             last_in_block;
    } t_smp;

    typedef struct packed {
        logic [WordW-1:0] result_word;
        logic             sample_bad;
        logic             block_ok;
        logic             last_out;
    } t_res;

    typedef struct packed {
        logic source_format;
        logic target_format;
    } t_fmt;

endpackage

// File: design/pfi_in_if.sv
// Valid/ready channel carrying one input sample word.
interface pfi_in_if;
    import pfi_pkg::*;
    logic valid;
    logic ready;
    t_smp data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: design/pfi_out_if.sv
// Valid/ready channel carrying one converted result word.
interface pfi_out_if;
    import pfi_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: design/pfi_cfg_if.sv
// Valid/ready register write channel.
interface pfi_cfg_if;
    import pfi_pkg::*;
    logic                valid;
    logic                ready;
    logic [CfgAddrW-1:0] addr;
    logic [WordW-1:0]    wdata;
    modport source(output valid, output addr, output wdata, input ready);
    modport sink(input valid, input addr, input wdata, output ready);
endinterface

// File: design/pcm_float_int16_converter.sv
// Top level: input register, conversion logic, result register.
// An accepted word is held in the input register, converted, and shown from the result register.
// Throughput: one word per cycle while the output is not stalled, set by the two-register pipeline.
// Reset: format registers select int16 to int16, pipeline empty, block flag clear.
module pcm_float_int16_converter (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pfi_in_if.sink   i_smp,
    pfi_out_if.source o_res,
    pfi_cfg_if.sink  i_cfg
);
    import pfi_pkg::*;

    t_fmt             r_fmt;
    logic             r_in_valid;
    t_smp             r_in;
    logic             r_out_valid;
    t_res             r_out;
    logic             r_err_seen;
    logic             advance;
    logic [WordW-1:0] conv_result;
    logic             conv_bad;
    logic             n_err;

    assign advance     = !r_out_valid || o_res.ready;
    assign i_smp.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    pfi_convert u_convert (
        .i_fmt    (r_fmt),
        .i_word   (r_in.sample_word),
        .o_result (conv_result),
        .o_bad    (conv_bad)
    );

    assign n_err = r_err_seen || conv_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt       <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_err_seen  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.addr)
                    CfgSourceFormat: r_fmt.source_format <= i_cfg.wdata[0];
                    CfgTargetFormat: r_fmt.target_format <= i_cfg.wdata[0];
                    default: ;
                endcase
            end
            if (i_smp.ready) begin
                r_in_valid <= i_smp.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_err_seen <= r_in.last_in_block ? 1'b0 : n_err;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_smp.ready && i_smp.valid) begin
            r_in <= i_smp.data;
        end
        if (advance && r_in_valid) begin
            r_out.result_word <= conv_result;
            r_out.sample_bad  <= conv_bad;
            r_out.block_ok    <= r_in.last_in_block && !n_err;
            r_out.last_out    <= r_in.last_in_block;
        end
    end

endmodule

// File: design/pfi_convert.sv
// Combinational sample conversion between int16 PCM and float32, with int16 pass-through and float32 clamping.
module pfi_convert (
    input  pfi_pkg::t_fmt             i_fmt,
    input  logic [pfi_pkg::WordW-1:0] i_word,
    output logic [pfi_pkg::WordW-1:0] o_result,
    output logic                      o_bad
);
    import pfi_pkg::*;

    logic [15:0] s16;
    logic        s_neg;
    logic [15:0] s_mag;
    logic [3:0]  s_lead;
    logic [23:0] s_norm;
    logic [31:0] int_to_float;

    logic        f_neg;
    logic [7:0]  f_exp;
    logic        f_gt_one;
    logic        f_ge_one;
    logic [23:0] f_man;
    logic [38:0] f_prod;
    logic [7:0]  f_sh;
    logic [38:0] f_trunc;
    logic [16:0] f_round;
    logic [15:0] f_int;
    logic [31:0] float_clamped;

    always_comb begin
        s16    = i_word[15:0];
        s_neg  = s16[15];
        s_mag  = s_neg ? (16'd0 - s16) : s16;
        s_lead = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (s_mag[i]) begin
                s_lead = 4'(i);
            end
        end
        s_norm = 24'(s_mag) << (5'd23 - 5'(s_lead));
        if (s_mag == 16'd0) begin
            int_to_float = '0;
        end else begin
            int_to_float = {s_neg, 8'd112 + 8'(s_lead), s_norm[22:0]};
        end
    end

    always_comb begin
        f_neg    = i_word[31];
        f_exp    = i_word[30:23];
        f_gt_one = i_word[30:0] > FloatOneMag;
        f_ge_one = i_word[30:0] >= FloatOneMag;
        f_man    = {f_exp != 8'd0, i_word[22:0]};
        if (f_neg) begin
            f_prod = {f_man, 15'd0};
        end else begin
            f_prod = {f_man, 15'd0} - 39'(f_man);
        end
        f_sh = 8'd149 - f_exp;
        if (f_exp > 8'd149 || f_sh >= 8'd39) begin
            f_trunc = '0;
        end else begin
            f_trunc = f_prod >> f_sh[5:0];
        end
        f_round = 17'((40'(f_trunc) + 40'd1) >> 1);
        if (f_ge_one) begin
            f_int = f_neg ? 16'h8000 : 16'h7FFF;
        end else begin
            f_int = f_neg ? (16'd0 - f_round[15:0]) : f_round[15:0];
        end
        if (f_gt_one) begin
            float_clamped = {f_neg, FloatOneMag};
        end else begin
            float_clamped = i_word;
        end
    end

    always_comb begin
        o_bad    = 1'b0;
        o_result = '0;
        if (i_fmt.source_format == FmtInt16) begin
            if (i_fmt.target_format == FmtInt16) begin
                o_result = {16'd0, s16};
            end else begin
                o_result = int_to_float;
            end
        end else if (f_exp == 8'hFF) begin
            o_bad = 1'b1;
        end else if (i_fmt.target_format == FmtFloat) begin
            o_result = float_clamped;
        end else begin
            o_result = {16'd0, f_int};
        end
    end

endmodule

// File: bench/pfi_checker.sv
// Checker for the PCM float/int16 converter: predicts each result word and compares it.
module pfi_checker
    import pfi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    pfi_in_if    i_smp,
    pfi_out_if   i_res,
    pfi_cfg_if   i_cfg,
    output int   o_fail,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic src_fmt;
    logic tgt_fmt;
    logic block_bad_seen;
    t_res result_q[$];

    function automatic logic [31:0] pcm_to_float(input logic [15:0] low);
        logic [31:0] mag;
        logic [31:0] bits;
        int p;
        bits = '0;
        mag = low[15] ? (32'd65536 - {16'h0, low}) : {16'h0, low};
        if (mag != 0) begin
            p = 0;
            for (int k = 0; k < 17; k++) begin
                if (mag[k]) p = k;
            end
            bits[31] = low[15];
            bits[30:23] = 8'(p + 112);
            bits[22:0] = 23'(mag << (23 - p));
        end
        return bits;
    endfunction

    function automatic logic [31:0] float_to_pcm(input logic [31:0] w);
        logic [7:0] ex;
        logic [63:0] prod;
        logic [31:0] q;
        logic [31:0] val;
        int sh;
        if (w[30:0] >= FloatOneMag) begin
            q = w[31] ? 32'd32768 : 32'd32767;
        end else begin
            ex = w[30:23];
            prod = {40'h0, (ex == 0) ? 1'b0 : 1'b1, w[22:0]};
            prod = prod * (w[31] ? 64'd32768 : 64'd32767);
            sh = 150 - ((ex == 0) ? 1 : int'(ex));
            q = 32'(prod >> sh) + 32'((prod >> (sh - 1)) & 64'd1);
        end
        val = w[31] ? (32'd0 - q) : q;
        return {16'h0, val[15:0]};
    endfunction

    function automatic t_res convert_word(input logic [31:0] w, input logic sf, input logic tf);
        t_res r;
        r = '0;
        if (sf == FmtInt16) begin
            r.result_word = (tf == FmtInt16) ? {16'h0, w[15:0]} : pcm_to_float(w[15:0]);
        end else if (w[30:23] == 8'hFF) begin
            r.sample_bad = 1'b1;
        end else if (tf == FmtFloat) begin
            r.result_word = (w[30:0] > FloatOneMag) ? {w[31], FloatOneMag} : w;
        end else begin
            r.result_word = float_to_pcm(w);
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        t_res e;
        t_res got;
        int push;
        int pop;
        int errs;
        if (!i_rst_n) begin
            src_fmt <= FmtInt16;
            tgt_fmt <= FmtInt16;
            block_bad_seen <= 1'b0;
            o_fail <= 0;
            o_pending <= 0;
            result_q.delete();
        end else begin
            push = 0;
            pop = 0;
            errs = 0;
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.addr == CfgSourceFormat) src_fmt <= i_cfg.wdata[0];
                else if (i_cfg.addr == CfgTargetFormat) tgt_fmt <= i_cfg.wdata[0];
            end
            if (i_smp.valid && i_smp.ready) begin
                e = convert_word(i_smp.data.sample_word, src_fmt, tgt_fmt);
                e.last_out = i_smp.data.last_in_block;
                e.block_ok = i_smp.data.last_in_block && !(block_bad_seen || e.sample_bad);
                if (i_smp.data.last_in_block) block_bad_seen <= 1'b0;
                else if (e.sample_bad) block_bad_seen <= 1'b1;
                result_q.push_back(e);
                push = 1;
            end
            if (i_res.valid && i_res.ready) begin
                got = i_res.data;
                if (result_q.size() == 0) begin
                    $error("unexpected result word %h", got.result_word);
                    errs++;
                end else begin
                    e = result_q.pop_front();
                    pop = 1;
                    if (got.result_word !== e.result_word) begin
                        $error("result_word: expected %h, got %h", e.result_word, got.result_word);
                        errs++;
                    end
                    if (got.sample_bad !== e.sample_bad) begin
                        $error("sample_bad: expected %b, got %b", e.sample_bad, got.sample_bad);
                        errs++;
                    end
                    if (got.block_ok !== e.block_ok) begin
                        $error("block_ok: expected %b, got %b", e.block_ok, got.block_ok);
                        errs++;
                    end
                    if (got.last_out !== e.last_out) begin
                        $error("last_out: expected %b, got %b", e.last_out, got.last_out);
                        errs++;
                    end
                end
            end
            o_fail <= o_fail + errs;
            o_pending <= o_pending + push - pop;
        end
    end

endmodule

// File: bench/tb.sv
// Testbench top for the PCM float/int16 converter: stimulus, stalls and verdict.
module tb;
    import pfi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int fail_count;
    int pending_count;
    int cycle_count = 0;
    int stall_left = 0;
    bit no_stall = 1'b0;
    bit no_gap = 1'b0;

    pfi_in_if smp_if();
    pfi_out_if res_if();
    pfi_cfg_if cfg_if();

    pcm_float_int16_converter DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_smp  (smp_if.sink),
        .o_res  (res_if.source),
        .i_cfg  (cfg_if.sink)
    );

    pfi_checker u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_smp    (smp_if),
        .i_res    (res_if),
        .i_cfg    (cfg_if),
        .o_fail   (fail_count),
        .o_pending(pending_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        smp_if.valid = 1'b0;
        smp_if.data = '0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.addr = '0;
        cfg_if.wdata = '0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (res_if.valid && res_if.ready && !no_stall) begin
            stall_left <= $urandom_range(0, 6);
            res_if.ready <= 1'b0;
        end else if (stall_left > 0 && !no_stall) begin
            stall_left <= stall_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            stall_left <= 0;
            res_if.ready <= 1'b1;
        end
    end

    task automatic drain();
        do @(posedge i_clk); while (pending_count != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic bit_val);
        cfg_if.valid <= 1'b1;
        cfg_if.addr <= idx;
        cfg_if.wdata <= {31'($urandom()), bit_val};
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_formats(input logic sf, input logic tf);
        drain();
        write_reg(CfgSourceFormat, sf);
        write_reg(CfgTargetFormat, tf);
        write_reg(CfgTargetFormat + 8'(1 + $urandom_range(0, 253)), 1'(~sf));
        @(posedge i_clk);
    endtask

    task automatic send_word(input logic [31:0] w, input logic last);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_if.valid <= 1'b1;
        smp_if.data.sample_word <= w;
        smp_if.data.last_in_block <= last;
        do @(posedge i_clk); while (!smp_if.ready);
    endtask

    task automatic end_burst();
        smp_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_sample();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 9))
            0, 1: ;
            2, 3, 4, 5, 6: w[30:23] = 8'($urandom_range(100, 127));
            7: w[30:23] = 8'($urandom_range(126, 128));
            8: begin
                if ($urandom_range(0, 3) == 0) w[30:23] = 8'hFF;
                else if ($urandom_range(0, 1) == 0) w[30:23] = 8'h00;
                else w[30:0] = '0;
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: w[15:0] = 16'h8000;
                    1: w[15:0] = 16'h7FFF;
                    2: w[15:0] = 16'h0000;
                    default: ;
                endcase
            end
        endcase
        return w;
    endfunction

    initial begin
        logic [31:0] directed_words[$];
        logic [1:0] phase_fmt[$];
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_words = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
                           32'h4000_0000, 32'hC2C8_0000, 32'h3F7F_FFFF, 32'h3780_0000,
                           32'hB780_0000, 32'h0000_0001, 32'h7F80_0000, 32'hFFC0_0001};
        for (int s = 0; s < 2; s++) begin
            set_formats(FmtFloat, 1'(s));
            foreach (directed_words[k]) begin
                send_word(directed_words[k], (k % 5) == 4 || k == directed_words.size() - 1);
            end
            end_burst();
        end

        phase_fmt = '{2'b00, 2'b01, 2'b10, 2'b11, 2'b10, 2'b01, 2'b11, 2'b00};
        foreach (phase_fmt[p]) begin
            set_formats(phase_fmt[p][1], phase_fmt[p][0]);
            for (int n = 0; n < 190; n++) begin
                if (n % 50 == 0) begin
                    no_gap = ($urandom_range(0, 2) == 0);
                    no_stall = ($urandom_range(0, 2) == 0);
                end
                if (n == 95) begin
                    end_burst();
                    drain();
                end
                send_word(random_sample(), n == 189 || $urandom_range(0, 7) == 0);
            end
            end_burst();
        end
        no_stall = 1'b0;

        do @(posedge i_clk); while (pending_count != 0);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// File: pcm_float_int16_converter.f
design/pfi_pkg.sv
design/pfi_in_if.sv
design/pfi_out_if.sv
design/pfi_cfg_if.sv
design/pfi_convert.sv
design/pcm_float_int16_converter.sv
bench/pfi_checker.sv
bench/tb.sv
